// ===== rtl/core/pls_pkg.sv =====
// shared types and codes for the positional list store
`timescale 1ns / 1ps

package pls_pkg;

   // request kinds
   localparam logic [2:0] KIND_APPEND = 3'd0;
   localparam logic [2:0] KIND_INSERT = 3'd1;
   localparam logic [2:0] KIND_REMOVE = 3'd2;
   localparam logic [2:0] KIND_READ   = 3'd3;
   localparam logic [2:0] KIND_WRITE  = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_RD_LOAD,
      CELL_RD_SHIFT
   } cell_op_type;

endpackage

// ===== rtl/core/pls_if.sv =====
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps

interface pls_req_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  kind;
   logic        [5:0]  position;
   logic signed [31:0] value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pls_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] read_value;
   logic        [6:0]  entry_count;
   logic        [1:0]  status;

   modport source (output valid, read_value, entry_count, status, input ready);
   modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

// ===== rtl/core/pls_cell.sv =====
// one storage cell of the list chain with its read-path tap
`timescale 1ns / 1ps

module pls_cell #(
   parameter int WORD_BITS  = 32,
   parameter int CMP_W      = 7,
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  pls_pkg::cell_op_type op,
   input  logic [CMP_W-1:0]     target,
   input  logic [WORD_BITS-1:0] word,
   input  logic [WORD_BITS-1:0] lower_data,
   input  logic [WORD_BITS-1:0] upper_data,
   input  logic [WORD_BITS-1:0] upper_rd,
   output logic [WORD_BITS-1:0] data,
   output logic [WORD_BITS-1:0] rd
);
   import pls_pkg::*;

   localparam logic [CMP_W-1:0] IDX = CMP_W'(CELL_INDEX);

   logic [WORD_BITS-1:0] data_ff, data_in;
   logic [WORD_BITS-1:0] rd_ff, rd_in;

   // next entry and read tap from the broadcast operation
   always_comb begin
      data_in = data_ff;
      rd_in   = rd_ff;
      case (op)
         CELL_LOAD: begin
            if (IDX == target) data_in = word;
         end
         CELL_INSERT: begin
            if (IDX == target)     data_in = word;
            else if (IDX > target) data_in = lower_data;
         end
         CELL_REMOVE: begin
            if (IDX >= target) data_in = upper_data;
         end
         CELL_RD_LOAD: begin
            rd_in = (IDX == target) ? data_ff : '0;
         end
         CELL_RD_SHIFT: begin
            rd_in = upper_rd;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data = data_ff;
   assign rd   = rd_ff;

endmodule

// ===== rtl/core/positional_list_store.sv =====
// positional list store: ordered list in a chain of shifting cells
//
//   channel  dir  handshake          payload
//   req_chan in   valid/ready        kind, position, value
//   rsp_chan out  valid/ready        read_value, entry_count, status
//
// append, insert, remove, write and refused items answer in the cycle after
// they are taken: every cell updates at once. for a good read the entry is tapped
// into the read chain and moves one cell per cycle toward cell zero.
// reset clears the count and the control state; cell contents are not reset.
// a new request is taken when the controller is idle and the response
// register is empty or being drained in the same cycle.
`timescale 1ns / 1ps

module positional_list_store #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   pls_req_if.sink   req_chan,
   pls_rsp_if.source rsp_chan
);
   import pls_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [5:0]           shift_cnt_ff, shift_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic                 full;
   logic                 pos_bad;
   logic [CMP_W-1:0]     pos_ext;
   logic [CMP_W-1:0]     count_ext;
   cell_op_type          cell_op;
   logic [CMP_W-1:0]     cell_target;
   logic [WORD_BITS-1:0] in_word;
   logic signed [31:0]   head_value;

   logic [WORD_BITS-1:0] cell_data [DEPTH];
   logic [WORD_BITS-1:0] cell_rd   [DEPTH];

   // request word fit to the cell width, and cell zero tap back to 32 bits
   generate
      if (WORD_BITS <= 32) begin : g_narrow
         assign in_word = req_chan.value[WORD_BITS-1:0];
         if (WORD_BITS == 32) begin : g_same
            assign head_value = cell_rd[0];
         end else begin : g_ext
            assign head_value = {{(32-WORD_BITS){cell_rd[0][WORD_BITS-1]}}, cell_rd[0]};
         end
      end else begin : g_wide
         assign in_word    = {{(WORD_BITS-32){req_chan.value[31]}}, req_chan.value};
         assign head_value = cell_rd[0][31:0];
      end
   endgenerate

   assign accept    = req_chan.valid && req_chan.ready;
   assign pos_ext   = CMP_W'(req_chan.position);
   assign count_ext = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pos_bad   = (pos_ext >= count_ext);

   // controller: decode accepted requests, run the read shift
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      shift_cnt_in  = shift_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      cell_op       = CELL_HOLD;
      cell_target   = pos_ext;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_DONE;
               case (req_chan.kind)
                  KIND_APPEND: begin
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cell_op     = CELL_LOAD;
                        cell_target = count_ext;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  KIND_INSERT: begin
                     if (pos_bad) begin
                        rsp_status_in = STATUS_BAD_POS;
                     end else if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cell_op  = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_REMOVE: begin
                     if (pos_bad) begin
                        rsp_status_in = STATUS_BAD_POS;
                     end else begin
                        cell_op  = CELL_REMOVE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  KIND_READ: begin
                     if (pos_bad) begin
                        rsp_status_in = STATUS_BAD_POS;
                     end else begin
                        rsp_valid_in = 1'b0;
                        cell_op      = CELL_RD_LOAD;
                        shift_cnt_in = req_chan.position;
                        state_in     = ST_READ;
                     end
                  end
                  KIND_WRITE: begin
                     if (pos_bad) begin
                        rsp_status_in = STATUS_BAD_POS;
                     end else begin
                        cell_op = CELL_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         ST_READ: begin
            if (shift_cnt_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = head_value;
               rsp_count_in  = count_ff;
               rsp_status_in = STATUS_DONE;
               state_in      = ST_IDLE;
            end else begin
               cell_op      = CELL_RD_SHIFT;
               shift_cnt_in = shift_cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         shift_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         shift_cnt_ff <= shift_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // handshake and response outputs
   assign req_chan.ready       = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.entry_count = 7'(rsp_count_ff);
   assign rsp_chan.status      = rsp_status_ff;

   // chain of cells, each linked to the neighbors it has
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [WORD_BITS-1:0] lower_data;
         logic [WORD_BITS-1:0] upper_data;
         logic [WORD_BITS-1:0] upper_rd;

         if (i == 0) begin : g_first
            assign lower_data = '0;
         end else begin : g_lower
            assign lower_data = cell_data[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign upper_data = cell_data[i];
            assign upper_rd   = '0;
         end else begin : g_upper
            assign upper_data = cell_data[i+1];
            assign upper_rd   = cell_rd[i+1];
         end

         pls_cell #(
            .WORD_BITS  (WORD_BITS),
            .CMP_W      (CMP_W),
            .CELL_INDEX (i)
         ) u_cell (
            .clock      (clock),
            .op         (cell_op),
            .target     (cell_target),
            .word       (in_word),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .upper_rd   (upper_rd),
            .data       (cell_data[i]),
            .rd         (cell_rd[i])
         );
      end
   endgenerate

`ifndef SYNTHESIS
   // the count never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // no request is taken while a read is shifting
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !req_chan.ready)
      else $error("request taken during read shift");

   // non-read requests answer in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.kind != KIND_READ |=> rsp_valid_ff)
      else $error("missing response after single-cycle request");

   // the count moves only on a transfer in
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count changed without a request");

   // a read shift starts only on a transfer in
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !accept |=> state_ff == ST_IDLE)
      else $error("read started without a request");
`endif

endmodule
